@@ sv/erf_pkg.sv @@
// Shared types and constants for the event acceptance ray filter.
`default_nettype none
package erf_pkg;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic signed [23:0] mom_z;
    logic        [23:0] energy;
    logic               is_final;
    logic               event_last;
  } erf_in_t;

  typedef struct packed {
    logic       keep_event;
    logic [1:0] hit_face;
  } erf_out_t;

  typedef struct packed {
    logic        [23:0] energy_min;
    logic signed [19:0] x_min;
    logic signed [19:0] x_max;
    logic signed [19:0] y_min;
    logic signed [19:0] y_max;
    logic signed [19:0] z_front;
    logic signed [19:0] z_back;
  } erf_cfg_t;

  typedef struct packed {
    logic vld;
    logic second;
    logic want_pos;
    logic den_neg;
  } mac_op_t;

  typedef struct packed {
    logic vld;
    logic ok;
  } mac_res_t;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegEnergyMin = 3'd0;
  localparam logic [2:0] RegXMin      = 3'd1;
  localparam logic [2:0] RegXMax      = 3'd2;
  localparam logic [2:0] RegYMin      = 3'd3;
  localparam logic [2:0] RegYMax      = 3'd4;
  localparam logic [2:0] RegZFront    = 3'd5;
  localparam logic [2:0] RegZBack     = 3'd6;

  localparam logic [1:0] FaceNone  = 2'd0;
  localparam logic [1:0] FaceFront = 2'd1;
  localparam logic [1:0] FaceSide  = 2'd2;

  localparam logic [23:0] EnergyMinRst = 24'd1000;
  localparam logic [4:0]  NumSteps     = 5'd16;
  localparam logic [3:0]  NumTests     = 4'd8;

endpackage
`default_nettype wire

@@ sv/erf_regs.sv @@
// APB-style configuration register bank for the ray filter.
`default_nettype none
module erf_regs
  import erf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output erf_cfg_t              cfg
);

  erf_cfg_t   cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        RegEnergyMin: cfg_nxt.energy_min = pwdata[23:0];
        RegXMin:      cfg_nxt.x_min      = pwdata[19:0];
        RegXMax:      cfg_nxt.x_max      = pwdata[19:0];
        RegYMin:      cfg_nxt.y_min      = pwdata[19:0];
        RegYMax:      cfg_nxt.y_max      = pwdata[19:0];
        RegZFront:    cfg_nxt.z_front    = pwdata[19:0];
        RegZBack:     cfg_nxt.z_back     = pwdata[19:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegEnergyMin: prdata = {8'd0, cfg_r.energy_min};
      RegXMin:      prdata = {12'd0, cfg_r.x_min};
      RegXMax:      prdata = {12'd0, cfg_r.x_max};
      RegYMin:      prdata = {12'd0, cfg_r.y_min};
      RegYMax:      prdata = {12'd0, cfg_r.y_max};
      RegZFront:    prdata = {12'd0, cfg_r.z_front};
      RegZBack:     prdata = {12'd0, cfg_r.z_back};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r            <= '0;
      cfg_r.energy_min <= EnergyMinRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/erf_mac.sv @@
// Shared multiply-accumulate unit with strict sign test against a divisor sign.
`default_nettype none
module erf_mac
  import erf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mac_op_t            op,
  input  wire logic signed [20:0] op_a,
  input  wire logic signed [23:0] op_b,
  output mac_res_t                res
);

  logic signed [44:0] prod_r, acc_r;
  mac_op_t            ctl_r;
  mac_res_t           res_r;
  logic signed [46:0] sum;
  logic               num_pos, num_neg, ok;

  assign sum     = {{2{acc_r[44]}}, acc_r} + {{2{prod_r[44]}}, prod_r};
  assign num_neg = sum[46];
  assign num_pos = !sum[46] && (sum != '0);
  assign ok      = ctl_r.want_pos ? (ctl_r.den_neg ? num_neg : num_pos)
                                  : (ctl_r.den_neg ? num_pos : num_neg);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_r.vld && !ctl_r.second) acc_r <= prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      res_r <= '0;
    end else begin
      ctl_r     <= op;
      res_r.vld <= ctl_r.vld && ctl_r.second;
      res_r.ok  <= ok;
    end
  end

endmodule
`default_nettype wire

@@ sv/event_acceptance_ray_filter.sv @@
// Event acceptance ray filter: top level with sequencer, event state and ports.
//
// Usage: particles of an event arrive one transaction at a time on the in_
// channel (valid/ready). Each particle runs sixteen steps through one shared
// 21x24 multiply-accumulate unit, which forms eight exact cross-multiplied
// bound tests (four for the front plane, four for the side plane at x_min).
// in_ready is high only while the block is idle, so the next particle is
// accepted only once the last one has passed the sixteen issue steps of the
// multiplier, its two register stages, the count of the last test, the
// finish state and the idle state.
// On a particle marked event_last one result transaction (keep_event,
// hit_face) is loaded into the out_ register in the finish state; other
// particles give no result. If a result is still waiting when the next one
// is ready, the block holds until out_ready takes the old one. The user
// must write the registers over the cfg_ APB port only while the block is
// idle; the block does not enforce it. Synchronous reset clears the event
// state and out_valid, and sets energy_min to 1000 and all bounds to zero.
`default_nettype none
module event_acceptance_ray_filter
  import erf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire erf_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output erf_out_t              out_data,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AddrW-1:0] cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic      [31:0]      cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  erf_in_t            item_r;
  erf_cfg_t           cfg;
  logic [4:0]         cnt_r;
  logic [3:0]         res_cnt_r;
  logic [7:0]         tests_r;
  logic               event_hit_r;
  logic [1:0]         first_face_r;
  logic               out_valid_r;
  erf_out_t           out_data_r;
  mac_op_t            op;
  mac_res_t           res;
  logic signed [20:0] op_a, dz, dx;
  logic signed [23:0] op_b;
  logic [2:0]         tst;
  logic               cand, front, side;
  logic [1:0]         face;
  logic               hit_new;
  logic [1:0]         face_new;
  logic               can_load;

  erf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  function automatic logic signed [20:0] sdiff(logic signed [19:0] a, logic signed [19:0] b);
    sdiff = {a[19], a} - {b[19], b};
  endfunction

  assign tst = cnt_r[3:1];
  assign dz  = sdiff(cfg.z_front, item_r.pos_z);
  assign dx  = sdiff(cfg.x_min, item_r.pos_x);

  always_comb begin
    op_a = dz;
    op_b = item_r.mom_z;
    if (!cnt_r[0]) begin
      unique case (tst)
        3'd0: op_a = sdiff(item_r.pos_x, cfg.x_min);
        3'd1: op_a = sdiff(item_r.pos_x, cfg.x_max);
        3'd2: op_a = sdiff(item_r.pos_y, cfg.y_min);
        3'd3: op_a = sdiff(item_r.pos_y, cfg.y_max);
        3'd4: op_a = sdiff(item_r.pos_y, cfg.y_min);
        3'd5: op_a = sdiff(item_r.pos_y, cfg.y_max);
        3'd6: op_a = sdiff(item_r.pos_z, cfg.z_front);
        default: op_a = sdiff(item_r.pos_z, cfg.z_back);
      endcase
      op_b = tst[2] ? item_r.mom_x : item_r.mom_z;
    end else begin
      op_a = tst[2] ? dx : dz;
      unique case (tst[2:1])
        2'd0:    op_b = item_r.mom_x;
        2'd3:    op_b = item_r.mom_z;
        default: op_b = item_r.mom_y;
      endcase
    end
    op.vld      = (state_r == ST_CALC) && !cnt_r[4];
    op.second   = cnt_r[0];
    op.want_pos = !tst[0];
    op.den_neg  = tst[2] ? item_r.mom_x[23] : item_r.mom_z[23];
  end

  erf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (res)
  );

  assign cand  = item_r.is_final && (item_r.energy > cfg.energy_min)
                 && !item_r.mom_z[23] && (item_r.mom_z != '0);
  assign front = &tests_r[3:0];
  assign side  = (item_r.mom_x != '0) && (&tests_r[7:4]);

  always_comb begin
    priority if (!cand) face = FaceNone;
    else if (front)     face = FaceFront;
    else if (side)      face = FaceSide;
    else                face = FaceNone;
  end

  assign hit_new  = event_hit_r || (face != FaceNone);
  assign face_new = event_hit_r ? first_face_r : face;
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CALC;
      ST_CALC: if (res_cnt_r == NumTests) state_nxt = ST_FIN;
      ST_FIN:  if (!item_r.event_last || can_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    if (res.vld) tests_r <= {res.ok, tests_r[7:1]};
    if (state_r == ST_FIN && item_r.event_last && can_load) begin
      out_data_r.keep_event <= hit_new;
      out_data_r.hit_face   <= face_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      res_cnt_r    <= '0;
      event_hit_r  <= 1'b0;
      first_face_r <= FaceNone;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_valid && in_ready) begin
        cnt_r     <= '0;
        res_cnt_r <= '0;
      end else begin
        if (op.vld) cnt_r <= cnt_r + 5'd1;
        if (res.vld) res_cnt_r <= res_cnt_r + 4'd1;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_FIN) begin
        if (!item_r.event_last) begin
          event_hit_r  <= hit_new;
          first_face_r <= face_new;
        end else if (can_load) begin
          out_valid_r  <= 1'b1;
          event_hit_r  <= 1'b0;
          first_face_r <= FaceNone;
        end
      end
    end
  end

  a_face_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hit_face != 2'd3))
    else $error("invalid hit_face code");

  a_keep_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.keep_event == (out_data.hit_face != FaceNone)))
    else $error("keep_event disagrees with hit_face");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= NumSteps) && (res_cnt_r <= NumTests))
    else $error("sequencer count overrun");

endmodule
`default_nettype wire
